[sv/pwl_pkg.sv]
// ----------------------------------------------------------------------------
// pwl_pkg
// Types and constants shared by the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned EntryW  = 8;
  localparam int unsigned LenW    = 9;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = 9;
  localparam int unsigned NumW    = 64;
  localparam int unsigned DenW    = 33;

  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [ModeW-1:0] {
    MODE_EXACT  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_STAIRS = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ORDER    = 3'd3,
    ST_INDEX    = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERP_MODE  = 1'd0,
    CFG_TABLE_LENGTH = 1'd1
  } cfg_idx_e;

  localparam logic [LenW-1:0] LenReset = 9'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_CHK, S_LD_CMP, S_Q_CHK, S_Q_LAST, S_Q_RANGE, S_BS, S_BS_CMP,
    S_SEG_L, S_SEG_R, S_EVAL, S_MUL1, S_MUL2, S_DIV_GO, S_DIV_WAIT, S_EMIT
  } state_e;

  typedef struct packed {
    logic                    kind;
    logic [EntryW-1:0]       entry_index;
    logic signed [ValW-1:0]  x_value;
    logic signed [ValW-1:0]  f_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0]  result_value;
    logic [EntryW-1:0]       segment_index;
    logic [2:0]              status;
  } out_item_t;

endpackage

[sv/pwl_if.sv]
// ----------------------------------------------------------------------------
// pwl_in_if / pwl_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface pwl_in_if;
  logic              valid;
  logic              ready;
  pwl_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pwl_out_if;
  logic               valid;
  logic               ready;
  pwl_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/pwl_table_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// pwl_table_interpolator_unit
// Breakpoint table with load and query words; exact, linear and stairs modes.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+-------------------------------------
//  in_i     | in  | valid/ready       | kind, entry_index, x_value, f_value
//  out_o    | out | valid/ready       | result_value, segment_index, status
//  cfg      | in  | cfg_we_i          | cfg_index_i, cfg_data_i
//
// One word in flight. A load checks index and order; a query checks range,
// bisects and reads the segment; linear mode adds the multiply and divide.
// The table RAM's single read port sets the bisection pace.
// Reset clears control only; table contents are undefined until loaded.
// A finished result sits in the output register while the next word enters.
module pwl_table_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pwl_pkg::CfgDatW-1:0]   cfg_data_i,
  pwl_in_if.sink                        in_i,
  pwl_out_if.source                     out_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned VW = pwl_pkg::ValW;
  localparam int unsigned LW = pwl_pkg::LenW;

  pwl_pkg::state_e state_q, state_d;
  pwl_pkg::mode_e  mode_q;
  logic [LW-1:0]   len_q;

  logic [pwl_pkg::EntryW-1:0] e_q;
  logic signed [VW-1:0] x_q, f_q, first_q, first_d;
  logic signed [VW-1:0] x0_q, f0_q, x1_q, f1_q;
  logic [LW-1:0] lo_q, lo_d, hi_q, hi_d, mid, lo_clamp;
  logic signed [pwl_pkg::NumW-1:0] prod1_q, prod2_q;
  logic signed [VW-1:0] res_val_q, res_val_d;
  logic [pwl_pkg::EntryW-1:0] res_seg_q, res_seg_d;
  pwl_pkg::status_e res_st_q, res_st_d;
  pwl_pkg::out_item_t out_q;
  logic out_vld_q, out_load;

  logic          we;
  logic [AW-1:0] raddr;
  logic [2*VW-1:0] rdata;
  logic signed [VW-1:0] rd_x, rd_f;
  logic accept, div_start, div_done;
  logic signed [VW-1:0] quo;
  logic signed [VW:0] mul_b, span;
  logic signed [VW-1:0] mul_a;
  logic signed [2*VW:0] mul_full;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == pwl_pkg::S_IDLE);
  assign rd_x = rdata[2*VW-1:VW];
  assign rd_f = rdata[VW-1:0];
  assign mid  = LW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign lo_clamp = (lo_q > len_q - LW'(2)) ? len_q - LW'(2) : lo_q;
  assign span = (VW+1)'(x1_q) - (VW+1)'(x0_q);

  pwl_ram #(.WIDTH(2*VW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(e_q)),
    .wdata_i ({x_q, f_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pwl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod1_q + prod2_q),
    .den_i   (pwl_pkg::DenW'(span)),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // one shared multiplier, f0*(x1-x) then f1*(x-x0)
  always_comb begin
    if (state_q == pwl_pkg::S_MUL1) begin
      mul_a = f0_q;
      mul_b = (VW+1)'(x1_q) - (VW+1)'(x_q);
    end else begin
      mul_a = f1_q;
      mul_b = (VW+1)'(x_q) - (VW+1)'(x0_q);
    end
    mul_full = mul_a * mul_b;
  end

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    first_d   = first_q;
    res_val_d = res_val_q;
    res_seg_d = res_seg_q;
    res_st_d  = res_st_q;
    we        = 1'b0;
    raddr     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      pwl_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (in_i.data.kind == pwl_pkg::KIND_LOAD) ? pwl_pkg::S_LD_CHK
                                                           : pwl_pkg::S_Q_CHK;
        end
      end
      pwl_pkg::S_LD_CHK: begin
        res_val_d = '0;
        res_seg_d = '0;
        res_st_d  = pwl_pkg::ST_OK;
        raddr     = AW'(e_q - 1'b1);
        priority if (LW'(e_q) >= len_q || 32'(e_q) >= TABLE_DEPTH) begin
          res_st_d = pwl_pkg::ST_INDEX;
          state_d  = pwl_pkg::S_EMIT;
        end else if (e_q == '0) begin
          we      = 1'b1;
          state_d = pwl_pkg::S_EMIT;
        end else begin
          state_d = pwl_pkg::S_LD_CMP;
        end
      end
      pwl_pkg::S_LD_CMP: begin
        if (x_q <= rd_x) begin
          res_st_d = pwl_pkg::ST_ORDER;
        end else begin
          we = 1'b1;
        end
        state_d = pwl_pkg::S_EMIT;
      end
      pwl_pkg::S_Q_CHK: begin
        res_val_d = '0;
        res_seg_d = '0;
        raddr     = '0;
        if (len_q < LW'(2) || 32'(len_q) > TABLE_DEPTH) begin
          res_st_d = pwl_pkg::ST_INDEX;
          state_d  = pwl_pkg::S_EMIT;
        end else begin
          state_d = pwl_pkg::S_Q_LAST;
        end
      end
      pwl_pkg::S_Q_LAST: begin
        first_d = rd_x;
        raddr   = AW'(len_q - 1'b1);
        state_d = pwl_pkg::S_Q_RANGE;
      end
      pwl_pkg::S_Q_RANGE: begin
        if (x_q < first_q || x_q > rd_x) begin
          res_st_d = pwl_pkg::ST_RANGE;
          state_d  = pwl_pkg::S_EMIT;
        end else begin
          lo_d    = '0;
          hi_d    = len_q;
          state_d = pwl_pkg::S_BS;
        end
      end
      pwl_pkg::S_BS: begin
        if (hi_q - lo_q > LW'(1)) begin
          raddr   = AW'(mid);
          state_d = pwl_pkg::S_BS_CMP;
        end else begin
          lo_d    = lo_clamp;
          raddr   = AW'(lo_clamp);
          state_d = pwl_pkg::S_SEG_L;
        end
      end
      pwl_pkg::S_BS_CMP: begin
        if (x_q >= rd_x) begin
          lo_d = mid;
        end else begin
          hi_d = mid;
        end
        state_d = pwl_pkg::S_BS;
      end
      pwl_pkg::S_SEG_L: begin
        raddr   = AW'(lo_q + 1'b1);
        state_d = pwl_pkg::S_SEG_R;
      end
      pwl_pkg::S_SEG_R: begin
        state_d = pwl_pkg::S_EVAL;
      end
      pwl_pkg::S_EVAL: begin
        res_seg_d = lo_q[pwl_pkg::EntryW-1:0];
        res_st_d  = pwl_pkg::ST_OK;
        state_d   = pwl_pkg::S_EMIT;
        unique case (mode_q)
          pwl_pkg::MODE_EXACT: begin
            priority if (x_q == x0_q) begin
              res_val_d = f0_q;
            end else if (x_q == x1_q) begin
              res_val_d = f1_q;
            end else begin
              res_st_d = pwl_pkg::ST_NOTFOUND;
            end
          end
          pwl_pkg::MODE_LINEAR: begin
            priority if (x_q < x0_q || x_q > x1_q) begin
              res_st_d = pwl_pkg::ST_NOTFOUND;
            end else if (span == '0) begin
              res_val_d = f0_q;
            end else begin
              state_d = pwl_pkg::S_MUL1;
            end
          end
          pwl_pkg::MODE_STAIRS: res_val_d = f0_q;
          default:              res_st_d  = pwl_pkg::ST_NOTFOUND;
        endcase
      end
      pwl_pkg::S_MUL1: state_d = pwl_pkg::S_MUL2;
      pwl_pkg::S_MUL2: state_d = pwl_pkg::S_DIV_GO;
      pwl_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = pwl_pkg::S_DIV_WAIT;
      end
      pwl_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          res_val_d = quo;
          state_d   = pwl_pkg::S_EMIT;
        end
      end
      pwl_pkg::S_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = pwl_pkg::S_IDLE;
        end
      end
      default: state_d = pwl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pwl_pkg::S_IDLE;
      mode_q    <= pwl_pkg::MODE_LINEAR;
      len_q     <= pwl_pkg::LenReset;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == pwl_pkg::CFG_INTERP_MODE) begin
          mode_q <= pwl_pkg::mode_e'(cfg_data_i[pwl_pkg::ModeW-1:0]);
        end else begin
          len_q <= cfg_data_i[LW-1:0];
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q <= in_i.data.entry_index;
      x_q <= in_i.data.x_value;
      f_q <= in_i.data.f_value;
    end
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    first_q   <= first_d;
    res_val_q <= res_val_d;
    res_seg_q <= res_seg_d;
    res_st_q  <= res_st_d;
    if (state_q == pwl_pkg::S_SEG_L) begin
      x0_q <= rd_x;
      f0_q <= rd_f;
    end
    if (state_q == pwl_pkg::S_SEG_R) begin
      x1_q <= rd_x;
      f1_q <= rd_f;
    end
    if (state_q == pwl_pkg::S_MUL1) begin
      prod1_q <= mul_full[pwl_pkg::NumW-1:0];
    end
    if (state_q == pwl_pkg::S_MUL2) begin
      prod2_q <= mul_full[pwl_pkg::NumW-1:0];
    end
    if (out_load) begin
      out_q.result_value  <= res_val_q;
      out_q.segment_index <= res_seg_q;
      out_q.status        <= res_st_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

[sv/pwl_ram.sv]
// ----------------------------------------------------------------------------
// pwl_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pwl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/pwl_div.sv]
// ----------------------------------------------------------------------------
// pwl_div
// Radix-2 restoring divider, signed dividend by positive divisor, truncating.
// ----------------------------------------------------------------------------
module pwl_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pwl_pkg::NumW-1:0]   num_i,
  input  logic [pwl_pkg::DenW-1:0]          den_i,
  output logic                              done_o,
  output logic signed [pwl_pkg::ValW-1:0]   quo_o
);

  localparam int unsigned QW   = pwl_pkg::ValW;
  localparam int unsigned DW   = pwl_pkg::DenW;
  localparam int unsigned CntW = $clog2(QW);

  logic [DW-1:0]   rem_q, rem_d, den_q;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q, neg_q;
  logic [pwl_pkg::NumW-1:0] mag;
  logic [DW:0]     trial;
  logic            fits;

  // quotient magnitude stays below 2^32, so the upper half is already below den
  assign mag   = num_i[pwl_pkg::NumW-1] ? pwl_pkg::NumW'(-num_i) : num_i;
  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d = fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    quo_d = {quo_q[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(mag[pwl_pkg::NumW-1:QW]);
      quo_q <= mag[QW-1:0];
      den_q <= den_i;
      neg_q <= num_i[pwl_pkg::NumW-1];
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
